// File: src/refresh_compare_timer_regs_top_assert.svh
// Assertion macros shared by the refresh compare timer register block.
`ifndef REFRESH_COMPARE_TIMER_REGS_TOP_ASSERT_SVH
`define REFRESH_COMPARE_TIMER_REGS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCTR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rctr assertion failed");

// Next-cycle implication, checked outside reset.
`define RCTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rctr assertion failed");

`endif

// File: src/rctr_pkg.sv
// Types, register codes and constants of the refresh compare timer register block.
package rctr_pkg;

  // Kind of bus beat.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_t;

  // Register select codes.
  localparam logic [2:0] REG_BCR1  = 3'd0;
  localparam logic [2:0] REG_BCR2  = 3'd1;
  localparam logic [2:0] REG_WCR1  = 3'd2;
  localparam logic [2:0] REG_WCR2  = 3'd3;
  localparam logic [2:0] REG_DCR   = 3'd4;
  localparam logic [2:0] REG_RTCSR = 3'd5;
  localparam logic [2:0] REG_RTCNT = 3'd6;
  localparam logic [2:0] REG_RTCOR = 3'd7;

  // Write masks and fixed bits.
  localparam logic [15:0] BCR1_MASK  = 16'h010F;
  localparam logic [15:0] BCR1_FIXED = 16'h2000;
  localparam logic [15:0] WCR2_MASK  = 16'h003F;
  localparam logic [15:0] DCR_MASK   = 16'hFFB7;
  localparam logic [15:0] LOW_HALF   = 16'h00FF;
  localparam logic [15:0] HIGH_HALF  = 16'hFF00;

  // Reset values of the bus and wait control registers.
  localparam logic [15:0] BCR1_RESET = 16'h200F;
  localparam logic [15:0] BCR2_RESET = 16'hFFFF;
  localparam logic [15:0] WCR1_RESET = 16'hFFFF;
  localparam logic [15:0] WCR2_RESET = 16'h000F;

  // Timer status bit positions.
  localparam int CMF_POS  = 6;
  localparam int CMIE_POS = 5;
  localparam int CKS_LSB  = 2;
  localparam int RFSH_POS = 1;
  localparam int RMD_POS  = 0;

  // One input beat.
  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_select;
    logic        byte_access;
    logic        byte_low;
    logic [15:0] write_data;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] read_data;
    logic        cmi_request;
    logic        refresh_pulse;
  } result_t;

  // Held item and the strobe that commits it.
  typedef struct packed {
    logic  fire;
    item_t item;
  } step_t;

  // Prescaler tap for each clock-select code; zero means stopped.
  function automatic logic [3:0] div_shift(input logic [2:0] cks);
    logic [3:0] sh;
    case (cks)
      3'd0:    sh = 4'd0;
      3'd1:    sh = 4'd1;
      3'd2:    sh = 4'd3;
      3'd3:    sh = 4'd5;
      3'd4:    sh = 4'd7;
      3'd5:    sh = 4'd9;
      3'd6:    sh = 4'd11;
      3'd7:    sh = 4'd12;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

// File: src/rctr_req_if.sv
// Request channel interface: bus beats into the register block.
interface rctr_req_if import rctr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  reg_select;
  logic        byte_access;
  logic        byte_low;
  logic [15:0] write_data;

  modport source (output valid, action, reg_select, byte_access, byte_low, write_data,
                  input ready);
  modport sink (input valid, action, reg_select, byte_access, byte_low, write_data,
                output ready);
endinterface

// File: src/rctr_rsp_if.sv
// Response channel interface: result beats out of the register block.
interface rctr_rsp_if import rctr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        cmi_request;
  logic        refresh_pulse;

  modport source (output valid, read_data, cmi_request, refresh_pulse, input ready);
  modport sink (input valid, read_data, cmi_request, refresh_pulse, output ready);
endinterface

// File: src/refresh_compare_timer_regs_top.sv
// Top level of the refresh compare timer register block with its result register.
//
//   channel | modport | beat carries                                   | role
//   req     | sink    | action, reg_select, byte_access, byte_low,     | tick, read or write
//           |         | write_data                                     |
//   rsp     | source  | read_data, cmi_request, refresh_pulse          | one result per request
//
// Each request passes through the input register, then the result register, before
// its result appears. A new request can be accepted every cycle while rsp does not stall.
// The prescaler advances only on tick beats, one step per beat; the timer steps only on ticks at a divided edge.
// Reset is synchronous; it restores the register reset values and empties both stages.
// A stall on rsp holds the result register, then the input register, before req.ready drops.
module refresh_compare_timer_regs_top import rctr_pkg::*; #(
  parameter int PRESCALE_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  rctr_req_if.sink   req,
  rctr_rsp_if.source rsp
);

  step_t   step;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    load_out;

  // The result register loads when empty or when its beat is taken.
  assign load_out = !out_valid || rsp.ready;

  rctr_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (load_out),
    .step    (step)
  );

  rctr_regfile #(
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_regfile (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .res  (res)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= step.fire;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (step.fire) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = out_res.read_data;
  assign rsp.cmi_request   = out_res.cmi_request;
  assign rsp.refresh_pulse = out_res.refresh_pulse;

endmodule

// File: src/rctr_in_stage.sv
// Input register stage: holds one request beat until the result side can take it.
`include "refresh_compare_timer_regs_top_assert.svh"

module rctr_in_stage import rctr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rctr_req_if.sink   req,
  input  logic       advance,
  output step_t      step
);

  logic  stage_valid;
  item_t stage_item;

  // A held beat leaves whenever the result register can load.
  assign step.fire = stage_valid && advance;
  assign step.item = stage_item;
  assign req.ready = !stage_valid || advance;

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_item.action      <= req.action;
      stage_item.reg_select  <= req.reg_select;
      stage_item.byte_access <= req.byte_access;
      stage_item.byte_low    <= req.byte_low;
      stage_item.write_data  <= req.write_data;
    end
  end

  // An empty stage always takes a beat, and a full one that cannot move holds it.
  `RCTR_ASSERT_NOW(a_empty_ready, clk, rst, !stage_valid, req.ready)
  `RCTR_ASSERT_NEXT(a_stall_holds, clk, rst, stage_valid && !advance, stage_valid)

endmodule

// File: src/rctr_regfile.sv
// Register file, prescaler and compare timer; computes one result per committed beat.
`include "refresh_compare_timer_regs_top_assert.svh"

module rctr_regfile import rctr_pkg::*; #(
  parameter int PRESCALE_BITS = 12
) (
  input  logic    clk,
  input  logic    rst,
  input  step_t   step,
  output result_t res
);

  logic [15:0] bus_ctrl_one, bus_ctrl_one_next;
  logic [15:0] bus_ctrl_two, bus_ctrl_two_next;
  logic [15:0] wait_ctrl_one, wait_ctrl_one_next;
  logic [15:0] wait_ctrl_two, wait_ctrl_two_next;
  logic [15:0] dram_ctrl, dram_ctrl_next;
  logic [6:0]  timer_status, timer_status_next;
  logic        flag_seen_set, flag_seen_set_next;
  logic [7:0]  timer_count, timer_count_next;
  logic [7:0]  timer_constant, timer_constant_next;
  logic [PRESCALE_BITS-1:0] phase_count, phase_count_next;

  logic [15:0] cur_value;
  logic [15:0] write_value;
  logic [PRESCALE_BITS-1:0] phase_inc;
  logic [PRESCALE_BITS-1:0] div_mask;
  logic [3:0]  shift;
  logic        count_edge;
  logic        cmf_keep;
  item_t       it;

  assign it = step.item;

  // Current word of the selected register.
  always_comb begin
    case (it.reg_select)
      REG_BCR1:  cur_value = bus_ctrl_one;
      REG_BCR2:  cur_value = bus_ctrl_two;
      REG_WCR1:  cur_value = wait_ctrl_one;
      REG_WCR2:  cur_value = wait_ctrl_two;
      REG_DCR:   cur_value = dram_ctrl;
      REG_RTCSR: cur_value = {9'd0, timer_status};
      REG_RTCNT: cur_value = {8'd0, timer_count};
      REG_RTCOR: cur_value = {8'd0, timer_constant};
      default:   cur_value = 16'd0;
    endcase
  end

  // Merge a byte write into the other half of the current word.
  always_comb begin
    if (!it.byte_access) begin
      write_value = it.write_data;
    end else if (it.byte_low) begin
      write_value = (cur_value & HIGH_HALF) | (it.write_data & LOW_HALF);
    end else begin
      write_value = (cur_value & LOW_HALF) | {it.write_data[7:0], 8'd0};
    end
  end

  // Prescaler edge detect: the low bits selected by the clock select all wrap to zero.
  assign phase_inc  = phase_count + 1'b1;
  assign shift      = div_shift(timer_status[CKS_LSB +: 3]);
  assign div_mask   = ~({PRESCALE_BITS{1'b1}} << shift);
  assign count_edge = (shift != 4'd0) && ((phase_inc & div_mask) == '0);

  // CMF survives a write unless it was seen set and zero is written.
  assign cmf_keep = timer_status[CMF_POS] &&
                    !(flag_seen_set && !write_value[CMF_POS]);

  // Next state and result of the held beat.
  always_comb begin
    bus_ctrl_one_next   = bus_ctrl_one;
    bus_ctrl_two_next   = bus_ctrl_two;
    wait_ctrl_one_next  = wait_ctrl_one;
    wait_ctrl_two_next  = wait_ctrl_two;
    dram_ctrl_next      = dram_ctrl;
    timer_status_next   = timer_status;
    flag_seen_set_next  = flag_seen_set;
    timer_count_next    = timer_count;
    timer_constant_next = timer_constant;
    phase_count_next    = phase_count;
    res.read_data       = 16'd0;
    res.refresh_pulse   = 1'b0;

    case (action_t'(it.action))
      ACT_TICK: begin
        phase_count_next = phase_inc;
        if (count_edge) begin
          if (timer_count == timer_constant) begin
            timer_count_next           = 8'd0;
            timer_status_next[CMF_POS] = 1'b1;
            res.refresh_pulse = timer_status[RFSH_POS] && !timer_status[RMD_POS];
          end else begin
            timer_count_next = timer_count + 8'd1;
          end
        end
      end
      ACT_READ: begin
        if (!it.byte_access) begin
          res.read_data = cur_value;
        end else if (it.byte_low) begin
          res.read_data = cur_value & LOW_HALF;
        end else begin
          res.read_data = {8'd0, cur_value[15:8]};
        end
        // A word or low-byte read of RTCSR marks a set CMF as seen.
        if ((it.reg_select == REG_RTCSR) && timer_status[CMF_POS] &&
            (!it.byte_access || it.byte_low)) begin
          flag_seen_set_next = 1'b1;
        end
      end
      ACT_WRITE: begin
        case (it.reg_select)
          REG_BCR1:  bus_ctrl_one_next  = (write_value & BCR1_MASK) | BCR1_FIXED;
          REG_BCR2:  bus_ctrl_two_next  = write_value;
          REG_WCR1:  wait_ctrl_one_next = write_value;
          REG_WCR2:  wait_ctrl_two_next = write_value & WCR2_MASK;
          REG_DCR:   dram_ctrl_next     = write_value & DCR_MASK;
          REG_RTCSR: begin
            timer_status_next = {cmf_keep, write_value[5:0]};
            if (timer_status[CMF_POS] && !cmf_keep) begin
              flag_seen_set_next = 1'b0;
            end
          end
          REG_RTCNT: timer_count_next    = write_value[7:0];
          REG_RTCOR: timer_constant_next = write_value[7:0];
          default:   timer_constant_next = timer_constant;
        endcase
      end
      default: begin
        timer_status_next = timer_status;
      end
    endcase

    res.cmi_request = timer_status_next[CMF_POS] && timer_status_next[CMIE_POS];
  end

  // State registers commit only when a beat leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_ctrl_one   <= BCR1_RESET;
      bus_ctrl_two   <= BCR2_RESET;
      wait_ctrl_one  <= WCR1_RESET;
      wait_ctrl_two  <= WCR2_RESET;
      dram_ctrl      <= 16'd0;
      timer_status   <= 7'd0;
      flag_seen_set  <= 1'b0;
      timer_count    <= 8'd0;
      timer_constant <= 8'd0;
      phase_count    <= '0;
    end else if (step.fire) begin
      bus_ctrl_one   <= bus_ctrl_one_next;
      bus_ctrl_two   <= bus_ctrl_two_next;
      wait_ctrl_one  <= wait_ctrl_one_next;
      wait_ctrl_two  <= wait_ctrl_two_next;
      dram_ctrl      <= dram_ctrl_next;
      timer_status   <= timer_status_next;
      flag_seen_set  <= flag_seen_set_next;
      timer_count    <= timer_count_next;
      timer_constant <= timer_constant_next;
      phase_count    <= phase_count_next;
    end
  end

  // A refresh request always comes with a fresh compare match.
  `RCTR_ASSERT_NEXT(a_pulse_match, clk, rst, step.fire && res.refresh_pulse, timer_status[CMF_POS] && (timer_count == 8'd0))
  // Without a committed beat, CMF and the timer stay put.
  `RCTR_ASSERT_NEXT(a_idle_stable, clk, rst, !step.fire, $stable(timer_status) && $stable(timer_count) && $stable(phase_count))
  // BCR1 bit 13 reads as one at all times.
  `RCTR_ASSERT_NOW(a_bcr1_fixed, clk, rst, 1'b1, bus_ctrl_one[13])

endmodule

// File: sim/tb_refresh_compare_timer_regs_top.sv
// Testbench of the refresh compare timer register block, checked by a scoreboard.
module tb_refresh_compare_timer_regs_top import rctr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRESCALE_BITS = 12;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 40;
  localparam int BEATS_PER_PHASE = 180;

  // Action code that the block must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Clock-select codes used by name.
  localparam logic [2:0] CKS_STOP = 3'd0;
  localparam logic [2:0] CKS_DIV2 = 3'd1;
  localparam logic [2:0] CKS_DIV8 = 3'd2;
  localparam logic [2:0] CKS_DIV4096 = 3'd7;

  // Predicts the result of every accepted beat and checks what comes out.
  class timer_reg_scoreboard;
    logic [15:0] bcr1, bcr2, wcr1, wcr2, dcr;
    logic [6:0] status;
    bit flag_read;
    logic [7:0] count, match_value;
    logic [PRESCALE_BITS-1:0] prescale;
    int unsigned tap_shift [8];
    result_t pending_results [$];
    int errors;

    function new();
      tap_shift = '{0, 1, 3, 5, 7, 9, 11, 12};
      bcr1 = BCR1_RESET;
      bcr2 = BCR2_RESET;
      wcr1 = WCR1_RESET;
      wcr2 = WCR2_RESET;
      dcr = '0;
      status = '0;
      flag_read = 1'b0;
      count = '0;
      match_value = '0;
      prescale = '0;
      errors = 0;
    endfunction

    function logic [15:0] read_register(logic [2:0] sel);
      case (sel)
        REG_BCR1: return bcr1;
        REG_BCR2: return bcr2;
        REG_WCR1: return wcr1;
        REG_WCR2: return wcr2;
        REG_DCR: return dcr;
        REG_RTCSR: return {9'd0, status};
        REG_RTCNT: return {8'd0, count};
        default: return {8'd0, match_value};
      endcase
    endfunction

    function void write_register(logic [2:0] sel, logic [15:0] v);
      logic flag;
      case (sel)
        REG_BCR1: bcr1 = (v & BCR1_MASK) | BCR1_FIXED;
        REG_BCR2: bcr2 = v;
        REG_WCR1: wcr1 = v;
        REG_WCR2: wcr2 = v & WCR2_MASK;
        REG_DCR: dcr = v & DCR_MASK;
        REG_RTCSR: begin
          flag = status[CMF_POS];
          // A zero written to the flag clears it only once it was read as set.
          if (flag && flag_read && !v[CMF_POS]) begin
            flag = 1'b0;
            flag_read = 1'b0;
          end
          status = v[6:0];
          status[CMF_POS] = flag;
        end
        REG_RTCNT: count = v[7:0];
        default: match_value = v[7:0];
      endcase
    endfunction

    // One tick: advance the prescaler, and the counter on a divided edge.
    function logic step_timer();
      int unsigned shift;
      logic pulse;
      pulse = 1'b0;
      prescale = prescale + 1'b1;
      shift = tap_shift[status[CKS_LSB +: 3]];
      if (shift == 0) return 1'b0;
      if ((prescale & ((1 << shift) - 1)) != 0) return 1'b0;
      if (count == match_value) begin
        count = '0;
        status[CMF_POS] = 1'b1;
        pulse = status[RFSH_POS] && !status[RMD_POS];
      end else begin
        count = count + 1'b1;
      end
      return pulse;
    endfunction

    function void note_request(item_t it);
      logic [15:0] word, data;
      result_t r;
      r = '0;
      case (it.action)
        ACT_TICK: r.refresh_pulse = step_timer();
        ACT_READ: begin
          word = read_register(it.reg_select);
          if (it.byte_access && !it.byte_low) begin
            r.read_data = word >> 8;
          end else begin
            r.read_data = it.byte_access ? (word & LOW_HALF) : word;
            // Only a word read or a low-byte read of the status register sees the flag.
            if (it.reg_select == REG_RTCSR && word[CMF_POS]) flag_read = 1'b1;
          end
        end
        ACT_WRITE: begin
          if (!it.byte_access) begin
            data = it.write_data;
          end else begin
            word = read_register(it.reg_select);
            data = it.byte_low ? ((word & HIGH_HALF) | (it.write_data & LOW_HALF))
                               : ((word & LOW_HALF) | (it.write_data << 8));
          end
          write_register(it.reg_select, data);
        end
        default: ;
      endcase
      r.cmi_request = status[CMF_POS] & status[CMIE_POS];
      pending_results.push_back(r);
    endfunction

    task report(string what);
      if (errors < 100) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %h, predicted %h", got.read_data, want.read_data));
      if (got.cmi_request !== want.cmi_request)
        report($sformatf("cmi_request %b, predicted %b", got.cmi_request, want.cmi_request));
      if (got.refresh_pulse !== want.refresh_pulse)
        report($sformatf("refresh_pulse %b, predicted %b", got.refresh_pulse,
                         want.refresh_pulse));
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  rctr_req_if req_ch ();
  rctr_rsp_if rsp_ch ();
  timer_reg_scoreboard board;
  int req_idle_pct;
  int rsp_idle_pct;
  int hold_request;
  int stall_cycles;
  int beats_sent;

  refresh_compare_timer_regs_top #(.PRESCALE_BITS(PRESCALE_BITS)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // Check every result beat and watch for a stuck handshake.
  always @(posedge clk) begin
    result_t seen;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen.read_data = rsp_ch.read_data;
      seen.cmi_request = rsp_ch.cmi_request;
      seen.refresh_pulse = rsp_ch.refresh_pulse;
      board.check_result(seen);
    end
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one beat, after a random gap, and hold it until it is taken.
  task automatic issue(logic [1:0] act, logic [2:0] sel, logic byte_acc, logic low,
                       logic [15:0] data);
    item_t it;
    it.action = act;
    it.reg_select = sel;
    it.byte_access = byte_acc;
    it.byte_low = low;
    it.write_data = data;
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= it.action;
    req_ch.reg_select <= it.reg_select;
    req_ch.byte_access <= it.byte_access;
    req_ch.byte_low <= it.byte_low;
    req_ch.write_data <= it.write_data;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(it);
    beats_sent++;
    @(negedge clk);
  endtask

  // Ticks carry random junk in the fields the block ignores for them.
  task automatic run_ticks(int n);
    repeat (n) issue(ACT_TICK, 3'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic noise_beat();
    issue(2'($urandom), 3'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
  endtask

  // Stop offering until every pending result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.outstanding() > 0) @(negedge clk);
  endtask

  function automatic logic [15:0] status_word(logic cmie, logic [2:0] cks, logic rfsh,
                                              logic rmd);
    logic [15:0] w;
    w = '0;
    w[CMIE_POS] = cmie;
    w[CKS_LSB +: 3] = cks;
    w[RFSH_POS] = rfsh;
    w[RMD_POS] = rmd;
    return w;
  endfunction

  // Timer programming sequences with random content, mixed with noise beats.
  task automatic run_phase(int src_pct, int dst_pct, bit with_hold);
    int goal;
    int pick;
    logic [2:0] cks;
    logic [15:0] csr;
    req_idle_pct = src_pct;
    rsp_idle_pct = dst_pct;
    goal = beats_sent + BEATS_PER_PHASE;
    if (with_hold) hold_request = HOLD_CYCLES;
    while (beats_sent < goal) begin
      pick = $urandom_range(9);
      cks = (pick < 6) ? CKS_DIV2 : (pick < 9) ? CKS_DIV8 : 3'($urandom);
      if ($urandom_range(3) == 0) noise_beat();
      issue(ACT_WRITE, REG_RTCOR, 1'b0, 1'b0,
            {8'($urandom), ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7))});
      if ($urandom_range(1)) issue(ACT_WRITE, REG_RTCNT, 1'($urandom), 1'($urandom),
                                   16'($urandom));
      csr = 16'($urandom);
      csr[CKS_LSB +: 3] = cks;
      issue(ACT_WRITE, REG_RTCSR, 1'($urandom), 1'b1, csr);
      run_ticks($urandom_range(2, 40));
      if ($urandom_range(3) == 0) issue(ACT_READ, REG_RTCNT, 1'b0, 1'b0, 16'($urandom));
      issue(ACT_READ, REG_RTCSR, 1'($urandom), 1'($urandom), 16'($urandom));
      if ($urandom_range(3) == 0) noise_beat();
      // Try to clear the flag, keeping the timer setup.
      csr[CMF_POS] = ($urandom_range(3) == 0);
      issue(ACT_WRITE, REG_RTCSR, 1'b0, 1'b0, csr);
      run_ticks($urandom_range(0, 10));
    end
    drain();
  endtask

  initial begin
    board = new();
    req_ch.valid = 1'b0;
    req_ch.action = ACT_TICK;
    req_ch.reg_select = REG_BCR1;
    req_ch.byte_access = 1'b0;
    req_ch.byte_low = 1'b0;
    req_ch.write_data = '0;
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_request = 0;
    beats_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values of every register.
    for (int r = 0; r < 8; r++) issue(ACT_READ, 3'(r), 1'b0, 1'b0, 16'h0000);
    // Write masks, byte halves and the ignored action code.
    issue(ACT_WRITE, REG_BCR1, 1'b0, 1'b0, 16'hFFFF);
    issue(ACT_READ, REG_BCR1, 1'b1, 1'b0, 16'h0000);
    issue(ACT_WRITE, REG_WCR2, 1'b1, 1'b0, 16'hFFFF);
    issue(ACT_READ, REG_WCR2, 1'b0, 1'b0, 16'h0000);
    issue(ACT_WRITE, REG_DCR, 1'b0, 1'b0, 16'hFFFF);
    issue(ACT_READ, REG_DCR, 1'b1, 1'b1, 16'h0000);
    issue(ACT_UNUSED, REG_RTCOR, 1'b1, 1'b1, 16'hFFFF);
    // Counter starts above the constant and wraps through 255; a 1 written to the flag is
    // ignored.
    issue(ACT_WRITE, REG_RTCNT, 1'b0, 1'b0, 16'h00FE);
    issue(ACT_WRITE, REG_RTCSR, 1'b0, 1'b0,
          status_word(1'b1, CKS_DIV2, 1'b1, 1'b0) | (16'h1 << CMF_POS));
    run_ticks(6);
    // The flag survives a high-byte write and a zero written before it was seen.
    issue(ACT_WRITE, REG_RTCSR, 1'b1, 1'b0, 16'h0000);
    issue(ACT_WRITE, REG_RTCSR, 1'b0, 1'b0, status_word(1'b1, CKS_DIV2, 1'b1, 1'b1));
    issue(ACT_READ, REG_RTCSR, 1'b1, 1'b0, 16'h0000);
    // Timer stopped, then a low-byte read arms the clear.
    issue(ACT_WRITE, REG_RTCSR, 1'b0, 1'b0, status_word(1'b1, CKS_STOP, 1'b1, 1'b0));
    run_ticks(2);
    issue(ACT_READ, REG_RTCSR, 1'b1, 1'b1, 16'h0000);
    issue(ACT_WRITE, REG_RTCSR, 1'b0, 1'b0, status_word(1'b0, CKS_STOP, 1'b0, 1'b0));
    issue(ACT_READ, REG_RTCSR, 1'b0, 1'b0, 16'h0000);
    drain();

    run_phase(11, 65, 1'b0);
    run_phase(65, 11, 1'b0);
    run_phase(0, 0, 1'b1);

    // Slowest divider: the prescaler keeps running while the counter mostly waits.
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    issue(ACT_WRITE, REG_RTCOR, 1'b0, 1'b0, 16'h0000);
    issue(ACT_WRITE, REG_RTCNT, 1'b0, 1'b0, 16'h0000);
    issue(ACT_WRITE, REG_RTCSR, 1'b0, 1'b0, status_word(1'b1, CKS_DIV4096, 1'b1, 1'b0));
    run_ticks(20);
    issue(ACT_READ, REG_RTCSR, 1'b0, 1'b0, 16'h0000);
    drain();

    repeat (4) @(posedge clk);
    if (board.outstanding() != 0) board.report("results still pending at end of run");
    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/rctr_pkg.sv
src/rctr_req_if.sv
src/rctr_rsp_if.sv
src/rctr_in_stage.sv
src/rctr_regfile.sv
src/refresh_compare_timer_regs_top.sv
sim/tb_refresh_compare_timer_regs_top.sv
